[design/lru_page_replacement_top_assert.svh]
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LRUPR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lru page replacement check failed");

// next-cycle implication, checked outside reset
`define LRUPR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lru page replacement check failed");

`endif

[design/lrupr_pkg.sv]
package lrupr_pkg;

	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 16;
	localparam int CFG_W         = 5;
	localparam int IDX_W         = 4;
	localparam int CNT_W         = 32;

	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

	typedef struct packed {
		logic             is_fault;
		logic [IDX_W-1:0] frame_index;
		logic             evicted_valid;
	} lrupr_res_t;

endpackage

[design/lrupr_fault_cnt.sv]
module lrupr_fault_cnt
	import lrupr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             upd,
	input  logic             fault,
	output logic [CNT_W-1:0] cnt_q,
	output logic [CNT_W-1:0] cnt_next
);

	// saturating at all ones
	assign cnt_next = (fault && (cnt_q != '1)) ? cnt_q + CNT_W'(1) : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (upd) begin
			cnt_q <= cnt_next;
		end
	end

endmodule

[design/lrupr_frames.sv]
module lrupr_frames
	import lrupr_pkg::*;
#(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 upd,
	input  logic [PAGE_BITS-1:0] page,
	input  logic [CFG_W-1:0]     frames_in_use,
	output lrupr_res_t           res,
	output logic [PAGE_BITS-1:0] evicted_page
);

	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int NW = ($clog2(FRAMES + 1) > CFG_W) ? $clog2(FRAMES + 1) : CFG_W;

	logic [PAGE_BITS-1:0] pages_q [FRAMES];
	logic [FW-1:0]        rank_q  [FRAMES];
	logic [FRAMES-1:0]    valid_q;

	logic [NW-1:0]        n_eff;
	logic [FRAMES-1:0]    active;
	logic [FRAMES-1:0]    hit_c;
	logic [FRAMES-1:0]    empty_c;
	logic [FRAMES-1:0]    hit_oh;
	logic [FRAMES-1:0]    empty_oh;
	logic [FRAMES-1:0]    victim_oh;
	logic [FRAMES-1:0]    sel_oh;
	logic [FRAMES-1:0]    age;
	logic                 hit;
	logic                 has_empty;
	logic                 fill;
	logic [FW-1:0]        slot;
	logic [FW-1:0]        sel_rank;
	logic [PAGE_BITS-1:0] old_page;

	// clamp frame count to 1..FRAMES
	always_comb begin
		n_eff = NW'(frames_in_use);
		if (n_eff == '0) begin
			n_eff = NW'(1);
		end else if (n_eff > NW'(FRAMES)) begin
			n_eff = NW'(FRAMES);
		end
	end

	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			active[i]  = NW'(i) < n_eff;
			hit_c[i]   = active[i] && valid_q[i] && (pages_q[i] == page);
			empty_c[i] = active[i] && !valid_q[i];
		end
	end

	// lowest set bit
	assign hit_oh    = hit_c & (~hit_c + FRAMES'(1));
	assign empty_oh  = empty_c & (~empty_c + FRAMES'(1));
	assign hit       = |hit_c;
	assign has_empty = |empty_c;
	assign fill      = !hit && has_empty;

	// oldest active frame, ties to the higher index
	always_comb begin
		logic is_max;
		for (int i = 0; i < FRAMES; i++) begin
			is_max = active[i];
			for (int j = 0; j < FRAMES; j++) begin
				if (j > i && active[j]) begin
					is_max = is_max && (rank_q[j] < rank_q[i]);
				end else if (j < i && active[j]) begin
					is_max = is_max && (rank_q[j] <= rank_q[i]);
				end
			end
			victim_oh[i] = is_max;
		end
	end

	assign sel_oh = hit ? hit_oh : (has_empty ? empty_oh : victim_oh);

	always_comb begin
		slot     = '0;
		sel_rank = '0;
		old_page = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (sel_oh[i]) begin
				slot     = slot | FW'(i);
				sel_rank = sel_rank | rank_q[i];
				old_page = old_page | pages_q[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			age[i] = !sel_oh[i] && valid_q[i] && (fill || (rank_q[i] < sel_rank));
		end
	end

	assign res.is_fault      = !hit;
	assign res.frame_index   = IDX_W'(slot);
	assign res.evicted_valid = !hit && !has_empty;
	assign evicted_page      = res.evicted_valid ? old_page : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (upd) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (sel_oh[i]) begin
					valid_q[i] <= 1'b1;
					rank_q[i]  <= '0;
				end else if (age[i]) begin
					rank_q[i] <= rank_q[i] + FW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (sel_oh[i]) begin
					pages_q[i] <= page;
				end
			end
		end
	end

endmodule

[design/lru_page_replacement_top.sv]
// a word accepted into the input register gets its tag compare and recency
// update combinationally, and the result enters the output register once
// that is empty or out_ready; one word per cycle while out_ready stays high
// reset: arst_n clears frame valid bits, ranks, fault count and both stage valid
// flags, and sets frames_in_use to 16; no clearing pass is needed
module lru_page_replacement_top
	import lrupr_pkg::*;
#(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PAGE_BITS-1:0] page_number,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 is_fault,
	output logic [IDX_W-1:0]     frame_index,
	output logic                 evicted_valid,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic [CNT_W-1:0]     fault_count
);

	logic [CFG_W-1:0]     frames_in_use_q;
	logic                 vld_s1;
	logic [PAGE_BITS-1:0] page_s1;
	logic                 vld_s2;
	lrupr_res_t           res_s2;
	logic [PAGE_BITS-1:0] evicted_page_s2;
	logic [CNT_W-1:0]     fault_count_s2;
	logic                 adv;
	lrupr_res_t           res;
	logic [PAGE_BITS-1:0] ev_page;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     cnt_next;

	assign adv      = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= FRAMES_IN_USE_RST;
		end else if (cfg_we) begin
			frames_in_use_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (out_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			page_s1 <= page_number;
		end
		if (adv) begin
			res_s2          <= res;
			evicted_page_s2 <= ev_page;
			fault_count_s2  <= cnt_next;
		end
	end

	lrupr_frames #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_frames (
		.clk           (clk),
		.arst_n        (arst_n),
		.upd           (adv),
		.page          (page_s1),
		.frames_in_use (frames_in_use_q),
		.res           (res),
		.evicted_page  (ev_page)
	);

	lrupr_fault_cnt u_fault_cnt (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (adv),
		.fault    (res.is_fault),
		.cnt_q    (cnt_q),
		.cnt_next (cnt_next)
	);

	assign out_valid     = vld_s2;
	assign is_fault      = res_s2.is_fault;
	assign frame_index   = res_s2.frame_index;
	assign evicted_valid = res_s2.evicted_valid;
	assign evicted_page  = evicted_page_s2;
	assign fault_count   = fault_count_s2;

	`include "lru_page_replacement_top_assert.svh"

	`LRUPR_ASSERT_NOW(a_evict_is_fault, vld_s2, !res_s2.evicted_valid || res_s2.is_fault)
	`LRUPR_ASSERT_NOW(a_hit_keeps_count, adv && !res.is_fault, cnt_next == cnt_q)
	`LRUPR_ASSERT_NOW(a_ready_when_empty, !vld_s2, in_ready)
	`LRUPR_ASSERT_NEXT(a_count_loaded, adv, fault_count_s2 == cnt_q)

endmodule
